// ----- rtl/dual_result_alu_with_flags_unit_assert.svh -----
// Assertion macros used by the ALU pipeline module.
`ifndef DUAL_RESULT_ALU_WITH_FLAGS_UNIT_ASSERT_SVH
`define DUAL_RESULT_ALU_WITH_FLAGS_UNIT_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define DRFALU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define DRFALU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/drfalu_pkg.sv -----
`timescale 1ns / 1ps
package drfalu_pkg;

  localparam int WORD_W = 32;
  localparam int HALF_W = WORD_W / 2;
  localparam int OP_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PASS  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_ANDOR = 3'd4,
    OP_XOR   = 3'd5,
    OP_RSVD  = 3'd6,
    OP_SWAP  = 3'd7
  } op_t;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [2*WORD_W-1:0] dword_t;

  typedef struct packed {
    logic v;
    logic c;
  } cv_t;

endpackage

// ----- rtl/drfalu_cmd_if.sv -----
`timescale 1ns / 1ps
interface drfalu_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] operand_a;
  logic        operand_a_valid;
  logic [31:0] operand_b;
  logic        operand_b_valid;

  modport source (
    output valid, operation, operand_a, operand_a_valid, operand_b, operand_b_valid,
    input  ready
  );
  modport sink (
    input  valid, operation, operand_a, operand_a_valid, operand_b, operand_b_valid,
    output ready
  );
endinterface

// ----- rtl/drfalu_res_if.sv -----
`timescale 1ns / 1ps
interface drfalu_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_a;
  logic        result_a_valid;
  logic [31:0] result_b;
  logic        result_b_valid;
  logic [3:0]  flags_a;
  logic [3:0]  flags_b;
  logic        carry_overflow_valid;

  modport source (
    output valid, result_a, result_a_valid, result_b, result_b_valid,
           flags_a, flags_b, carry_overflow_valid,
    input  ready
  );
  modport sink (
    input  valid, result_a, result_a_valid, result_b, result_b_valid,
           flags_a, flags_b, carry_overflow_valid,
    output ready
  );
endinterface

// ----- rtl/drfalu_mul.sv -----
`timescale 1ns / 1ps
module drfalu_mul (
  input  logic                clk,
  input  logic                en,
  input  drfalu_pkg::word_t   a,
  input  drfalu_pkg::word_t   b,
  output drfalu_pkg::dword_t  prod
);
  import drfalu_pkg::*;

  logic [WORD_W-1:0] pp_ll;
  logic [WORD_W-1:0] pp_lh;
  logic [WORD_W-1:0] pp_hl;
  logic [WORD_W-1:0] pp_hh;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= a[HALF_W-1:0]      * b[HALF_W-1:0];
      pp_lh <= a[HALF_W-1:0]      * b[WORD_W-1:HALF_W];
      pp_hl <= a[WORD_W-1:HALF_W] * b[HALF_W-1:0];
      pp_hh <= a[WORD_W-1:HALF_W] * b[WORD_W-1:HALF_W];
    end
  end

  assign prod = {pp_hh, pp_ll}
              + {{HALF_W{1'b0}}, pp_lh, {HALF_W{1'b0}}}
              + {{HALF_W{1'b0}}, pp_hl, {HALF_W{1'b0}}};

endmodule

// ----- rtl/dual_result_alu_with_flags_unit.sv -----
`timescale 1ns / 1ps
// Dual-result 32-bit ALU with zero, negative, overflow and carry flags for each result.
// It accepts one transaction per clock while no stall at the output holds the pipeline,
// and presents each result on the result channel from the flag stage; results leave in
// order. The pipeline has four stages: operand capture with subtrahend negation, the
// adders and the four 16x16 partial products of the multiplier, the partial product sum
// with result selection, and the flag stage that is the output register. A stall at the
// output holds the output stage, and a stage behind it is held only while every stage
// ahead of it is occupied, so empty stages keep filling.
module dual_result_alu_with_flags_unit (
  input logic         clk,
  input logic         rst,
  drfalu_cmd_if.sink  cmd,
  drfalu_res_if.source res
);
  import drfalu_pkg::*;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  // Stage 1: captured operands with the selected addends.
  op_t   s1_op;
  word_t s1_a;
  word_t s1_b;
  logic  s1_av;
  logic  s1_bv;
  word_t s1_add_a;
  word_t s1_add_b;

  // Stage 2: non-multiply results and arithmetic flags.
  op_t   s2_op;
  logic  s2_av;
  logic  s2_bv;
  word_t s2_ra;
  word_t s2_rb;
  cv_t   s2_cva;
  cv_t   s2_cvb;

  // Stage 3: selected and masked results.
  word_t s3_ya;
  word_t s3_yb;
  logic  s3_ya_v;
  logic  s3_yb_v;
  logic  s3_cov;
  cv_t   s3_cva;
  cv_t   s3_cvb;

  word_t  b_sext;
  word_t  add_a_next;
  word_t  add_b_next;
  logic [WORD_W:0] sum_a;
  logic [WORD_W:0] sum_b;
  word_t  ra_next;
  word_t  rb_next;
  cv_t    cva_next;
  cv_t    cvb_next;
  dword_t prod;
  logic   both;
  logic   ya_v_next;
  logic   yb_v_next;
  logic   cov_next;
  word_t  ya_next;
  word_t  yb_next;

  assign en4 = !v4 || res.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign cmd.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= cmd.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_comb begin
    b_sext = {{HALF_W{cmd.operand_b[HALF_W-1]}}, cmd.operand_b[HALF_W-1:0]};
    if (op_t'(cmd.operation) == OP_SUB) begin
      add_a_next = ~cmd.operand_b + word_t'(1);
      add_b_next = ~b_sext + word_t'(1);
    end else begin
      add_a_next = cmd.operand_b;
      add_b_next = b_sext;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op    <= op_t'(cmd.operation);
      s1_a     <= cmd.operand_a;
      s1_b     <= cmd.operand_b;
      s1_av    <= cmd.operand_a_valid;
      s1_bv    <= cmd.operand_b_valid;
      s1_add_a <= add_a_next;
      s1_add_b <= add_b_next;
    end
  end

  drfalu_mul u_mul (
    .clk  (clk),
    .en   (en2),
    .a    (s1_a),
    .b    (s1_b),
    .prod (prod)
  );

  always_comb begin
    sum_a = {1'b0, s1_a} + {1'b0, s1_add_a};
    sum_b = {1'b0, s1_a} + {1'b0, s1_add_b};
    ra_next  = '0;
    rb_next  = '0;
    cva_next = '0;
    cvb_next = '0;
    case (s1_op)
      OP_PASS: begin
        ra_next = s1_a;
        rb_next = s1_b;
      end
      OP_SWAP: begin
        ra_next = {s1_a[HALF_W-1:0], s1_a[WORD_W-1:HALF_W]};
        rb_next = {s1_b[HALF_W-1:0], s1_b[WORD_W-1:HALF_W]};
      end
      OP_ADD, OP_SUB: begin
        ra_next    = sum_a[WORD_W-1:0];
        rb_next    = sum_b[WORD_W-1:0];
        cva_next.c = sum_a[WORD_W];
        cvb_next.c = sum_b[WORD_W];
        cva_next.v = (s1_a[WORD_W-1] == s1_add_a[WORD_W-1])
                  && (sum_a[WORD_W-1] != s1_a[WORD_W-1]);
        cvb_next.v = (s1_a[WORD_W-1] == s1_add_b[WORD_W-1])
                  && (sum_b[WORD_W-1] != s1_a[WORD_W-1]);
      end
      OP_ANDOR: begin
        ra_next = s1_a & s1_b;
        rb_next = s1_a | s1_b;
      end
      OP_XOR: begin
        ra_next = s1_a ^ s1_b;
        rb_next = ~(s1_a ^ s1_b);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_op  <= s1_op;
      s2_av  <= s1_av;
      s2_bv  <= s1_bv;
      s2_ra  <= ra_next;
      s2_rb  <= rb_next;
      s2_cva <= cva_next;
      s2_cvb <= cvb_next;
    end
  end

  always_comb begin
    both = s2_av && s2_bv;
    case (s2_op)
      OP_PASS, OP_SWAP: begin
        ya_v_next = s2_av;
        yb_v_next = s2_bv;
        cov_next  = 1'b1;
      end
      OP_RSVD: begin
        ya_v_next = 1'b0;
        yb_v_next = 1'b0;
        cov_next  = 1'b0;
      end
      default: begin
        ya_v_next = both;
        yb_v_next = both;
        cov_next  = both;
      end
    endcase
    if (!ya_v_next) begin
      ya_next = '0;
    end else if (s2_op == OP_MUL) begin
      ya_next = prod[2*WORD_W-1:WORD_W];
    end else begin
      ya_next = s2_ra;
    end
    if (!yb_v_next) begin
      yb_next = '0;
    end else if (s2_op == OP_MUL) begin
      yb_next = prod[WORD_W-1:0];
    end else begin
      yb_next = s2_rb;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_ya   <= ya_next;
      s3_yb   <= yb_next;
      s3_ya_v <= ya_v_next;
      s3_yb_v <= yb_v_next;
      s3_cov  <= cov_next;
      s3_cva  <= cov_next ? s2_cva : '0;
      s3_cvb  <= cov_next ? s2_cvb : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      res.result_a             <= s3_ya;
      res.result_b             <= s3_yb;
      res.result_a_valid       <= s3_ya_v;
      res.result_b_valid       <= s3_yb_v;
      res.carry_overflow_valid <= s3_cov;
      res.flags_a <= {s3_ya_v && (s3_ya == '0), s3_ya_v && s3_ya[WORD_W-1], s3_cva.v, s3_cva.c};
      res.flags_b <= {s3_yb_v && (s3_yb == '0), s3_yb_v && s3_yb[WORD_W-1], s3_cvb.v, s3_cvb.c};
    end
  end

  assign res.valid = v4;

  `include "dual_result_alu_with_flags_unit_assert.svh"

  `DRFALU_ASSERT_SAME(a_full_when_blocked, !cmd.ready, v1 && v2 && v3 && v4, "Input blocked while the pipeline has a bubble.")
  `DRFALU_ASSERT_SAME(a_invalid_a_zero, res.valid && !res.result_a_valid, res.result_a == '0 && res.flags_a[3:2] == 2'b00, "Invalid result A is not cleared.")
  `DRFALU_ASSERT_SAME(a_invalid_b_zero, res.valid && !res.result_b_valid, res.result_b == '0 && res.flags_b[3:2] == 2'b00, "Invalid result B is not cleared.")
  `DRFALU_ASSERT_SAME(a_invalid_cv_zero, res.valid && !res.carry_overflow_valid, res.flags_a[1:0] == 2'b00 && res.flags_b[1:0] == 2'b00, "Invalid carry or overflow flag is set.")
  `DRFALU_ASSERT_NEXT(a_accept_fills, cmd.valid && cmd.ready, v1, "Accepted transaction did not enter the first stage.")

endmodule

// ----- tb/sv/dual_result_alu_with_flags_unit_tb.sv -----
`timescale 1ns / 1ps
module dual_result_alu_with_flags_unit_tb;
  import drfalu_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    word_t      ra;
    logic       ra_valid;
    word_t      rb;
    logic       rb_valid;
    logic [3:0] fa;
    logic [3:0] fb;
    logic       cv_valid;
  } alu_result_t;

  logic clk;
  logic rst;

  drfalu_cmd_if cmd_if ();
  drfalu_res_if res_if ();

  dual_result_alu_with_flags_unit u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  alu_result_t alu_results_due[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  int          sink_hold_len = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic word_t add_with_cv(input word_t x, input word_t y,
                                        output logic [1:0] cv);
    logic [WORD_W:0] full;
    word_t           sum;
    full = {1'b0, x} + {1'b0, y};
    sum = full[WORD_W-1:0];
    cv[0] = full[WORD_W];
    cv[1] = (x[WORD_W-1] == y[WORD_W-1]) && (sum[WORD_W-1] != x[WORD_W-1]);
    return sum;
  endfunction

  function automatic logic [3:0] zn_flags(input word_t r);
    return {(r == '0), r[WORD_W-1], 2'b00};
  endfunction

  function automatic alu_result_t compute_alu_result(input op_t op, input word_t a,
                                                     input logic a_ok, input word_t b,
                                                     input logic b_ok);
    alu_result_t r;
    logic        both;
    logic [1:0]  cva;
    logic [1:0]  cvb;
    word_t       b_full;
    word_t       b_half;
    dword_t      prod;
    both = a_ok && b_ok;
    r.ra = '0;
    r.rb = '0;
    r.ra_valid = 1'b0;
    r.rb_valid = 1'b0;
    r.cv_valid = 1'b0;
    cva = 2'b00;
    cvb = 2'b00;
    b_full = b;
    b_half = {{HALF_W{b[HALF_W-1]}}, b[HALF_W-1:0]};
    case (op)
      OP_PASS: begin
        r.ra = a;
        r.ra_valid = a_ok;
        r.rb = b;
        r.rb_valid = b_ok;
        r.cv_valid = 1'b1;
      end
      OP_SWAP: begin
        r.ra = {a[HALF_W-1:0], a[WORD_W-1:HALF_W]};
        r.ra_valid = a_ok;
        r.rb = {b[HALF_W-1:0], b[WORD_W-1:HALF_W]};
        r.rb_valid = b_ok;
        r.cv_valid = 1'b1;
      end
      OP_ADD, OP_SUB: begin
        if (op == OP_SUB) begin
          b_full = -b_full;
          b_half = -b_half;
        end
        r.ra = add_with_cv(a, b_full, cva);
        r.rb = add_with_cv(a, b_half, cvb);
        r.ra_valid = both;
        r.rb_valid = both;
        r.cv_valid = both;
      end
      OP_MUL: begin
        prod = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
        r.ra = prod[2*WORD_W-1:WORD_W];
        r.rb = prod[WORD_W-1:0];
        r.ra_valid = both;
        r.rb_valid = both;
        r.cv_valid = both;
      end
      OP_ANDOR: begin
        r.ra = a & b;
        r.rb = a | b;
        r.ra_valid = both;
        r.rb_valid = both;
        r.cv_valid = both;
      end
      OP_XOR: begin
        r.ra = a ^ b;
        r.rb = ~(a ^ b);
        r.ra_valid = both;
        r.rb_valid = both;
        r.cv_valid = both;
      end
      default: begin
      end
    endcase
    if (!r.ra_valid) r.ra = '0;
    if (!r.rb_valid) r.rb = '0;
    if (!r.cv_valid) begin
      cva = 2'b00;
      cvb = 2'b00;
    end
    r.fa = (r.ra_valid ? zn_flags(r.ra) : 4'b0000) | {2'b00, cva};
    r.fb = (r.rb_valid ? zn_flags(r.rb) : 4'b0000) | {2'b00, cvb};
    return r;
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    mismatches++;
    $display("result %0d: %s got %h want %h", results_seen, what, got, want);
  endtask

  task automatic check_field(input string what, input word_t got, input word_t want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic send_alu_op(input op_t op, input word_t a, input logic a_ok,
                             input word_t b, input logic b_ok);
    if (src_idle_en && $urandom_range(99) < 32) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.operation <= op;
    cmd_if.operand_a <= a;
    cmd_if.operand_a_valid <= a_ok;
    cmd_if.operand_b <= b;
    cmd_if.operand_b_valid <= b_ok;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    alu_results_due.push_back(compute_alu_result(op, a, a_ok, b, b_ok));
  endtask

  task automatic wait_for_results;
    cmd_if.valid <= 1'b0;
    while (alu_results_due.size() != 0) @(posedge clk);
  endtask

  function automatic word_t pick_operand();
    word_t v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      2: v = 32'h8000_0000;
      3: v = 32'h7fff_ffff;
      4: v = $urandom_range(16'hffff);
      5: v = {16'hffff, 1'b1, 15'($urandom)};
      6: v = {16'($urandom_range(16'hffff)), 16'h0000};
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_random_op;
    send_alu_op(op_t'($urandom_range(7)), pick_operand(), $urandom_range(99) < 85,
                pick_operand(), $urandom_range(99) < 85);
  endtask

  task automatic test_directed;
    send_alu_op(OP_PASS, 32'hffff_ffff, 1'b1, 32'h0000_0000, 1'b1);
    send_alu_op(OP_PASS, 32'h8000_0000, 1'b1, 32'h1234_5678, 1'b0);
    send_alu_op(OP_PASS, 32'h1234_5678, 1'b0, 32'hffff_ffff, 1'b1);
    send_alu_op(OP_SWAP, 32'h1234_5678, 1'b1, 32'hffff_0000, 1'b1);
    send_alu_op(OP_SWAP, 32'h0000_8000, 1'b1, 32'hdead_beef, 1'b0);
    send_alu_op(OP_ADD, 32'h7fff_ffff, 1'b1, 32'h0000_0001, 1'b1);
    send_alu_op(OP_ADD, 32'hffff_ffff, 1'b1, 32'h0000_0001, 1'b1);
    send_alu_op(OP_ADD, 32'h8000_0000, 1'b1, 32'h0000_8000, 1'b1);
    send_alu_op(OP_ADD, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1);
    send_alu_op(OP_ADD, 32'h0000_0001, 1'b0, 32'h0000_0001, 1'b1);
    send_alu_op(OP_SUB, 32'h0000_0005, 1'b1, 32'h0000_0000, 1'b1);
    send_alu_op(OP_SUB, 32'h0000_0000, 1'b1, 32'h0000_0001, 1'b1);
    send_alu_op(OP_SUB, 32'h8000_0000, 1'b1, 32'h0000_0001, 1'b1);
    send_alu_op(OP_SUB, 32'h7fff_ffff, 1'b1, 32'hffff_8000, 1'b1);
    send_alu_op(OP_SUB, 32'h0000_0003, 1'b1, 32'h0000_0003, 1'b0);
    send_alu_op(OP_MUL, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 1'b1);
    send_alu_op(OP_MUL, 32'h0000_0000, 1'b1, 32'hffff_ffff, 1'b1);
    send_alu_op(OP_MUL, 32'h0001_0000, 1'b1, 32'h0001_0000, 1'b0);
    send_alu_op(OP_ANDOR, 32'hffff_0000, 1'b1, 32'h0000_ffff, 1'b1);
    send_alu_op(OP_XOR, 32'ha5a5_a5a5, 1'b1, 32'ha5a5_a5a5, 1'b1);
    send_alu_op(OP_XOR, 32'h0000_0000, 1'b0, 32'hffff_ffff, 1'b0);
    send_alu_op(OP_RSVD, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 1'b1);
    send_alu_op(OP_RSVD, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0);
  endtask

  task automatic test_random(input int count, input bit with_idling);
    src_idle_en = with_idling;
    sink_idle_en = with_idling;
    repeat (count) send_random_op();
  endtask

  task automatic test_output_stall;
    src_idle_en = 1'b0;
    sink_hold_len = 80;
    repeat (40) send_random_op();
  endtask

  task automatic test_pause_until_empty;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    repeat (20) send_random_op();
    wait_for_results();
    repeat (20) send_random_op();
  endtask

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_len != 0) begin
        res_if.ready <= 1'b0;
        repeat (sink_hold_len) @(posedge clk);
        sink_hold_len = 0;
      end
      res_if.ready <= sink_idle_en ? ($urandom_range(99) >= 32) : 1'b1;
    end
  end

  always @(posedge clk) begin
    alu_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      results_seen++;
      if (alu_results_due.size() == 0) begin
        report_mismatch("unexpected result_a", res_if.result_a, '0);
      end else begin
        want = alu_results_due.pop_front();
        check_field("result_a", res_if.result_a, want.ra);
        check_field("result_a_valid", word_t'(res_if.result_a_valid),
                    word_t'(want.ra_valid));
        check_field("result_b", res_if.result_b, want.rb);
        check_field("result_b_valid", word_t'(res_if.result_b_valid),
                    word_t'(want.rb_valid));
        check_field("flags_a", word_t'(res_if.flags_a), word_t'(want.fa));
        check_field("flags_b", word_t'(res_if.flags_b), word_t'(want.fb));
        check_field("carry_overflow_valid", word_t'(res_if.carry_overflow_valid),
                    word_t'(want.cv_valid));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("dual_result_alu_with_flags_unit_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cmd_if.valid <= 1'b0;
    cmd_if.operation <= OP_PASS;
    cmd_if.operand_a <= '0;
    cmd_if.operand_a_valid <= 1'b0;
    cmd_if.operand_b <= '0;
    cmd_if.operand_b_valid <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(300, 1'b1);
    test_output_stall();
    test_pause_until_empty();
    test_random(300, 1'b0);
    test_random(220, 1'b1);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && alu_results_due.size() == 0) begin
      $display("dual_result_alu_with_flags_unit_tb OK");
    end else begin
      $display("dual_result_alu_with_flags_unit_tb NOT OK");
    end
    $finish;
  end
endmodule
